// ===== rtl/rcet_pkg.sv =====
// shared constants, types and command/status structs of the cluster extent tracker
`default_nettype none
package rcet_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);

  localparam int RANGE_W = 16;
  localparam int AZ_W    = 12;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [RANGE_W-1:0] RANGE_MAX = 16'hFFFF;
  localparam logic [AZ_W-1:0]    AZ_MAX    = 12'hFFF;
  localparam logic [AZ_W:0]      AZ_TURN   = 13'd4096;
  localparam logic [AZ_W-1:0]    AZ_HALF   = 12'd2048;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_CLOSE  = 2'd3;

  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [AZ_W-1:0]    azimuth;
    logic               kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic shift_start;
    logic shift_step;
    logic shift_end;
    logic scan_start;
    logic scan_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic shift_needed;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/rcet_in_if.sv =====
// input channel of the cluster extent tracker: one operation per item
`default_nettype none
interface rcet_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [rcet_pkg::RANGE_W-1:0] point_range;
  logic [rcet_pkg::AZ_W-1:0]    point_azimuth;
  logic                        point_is_rbs;
  logic [rcet_pkg::POS_W-1:0]   position;

  modport source (output valid, op, point_range, point_azimuth, point_is_rbs, position,
                  input ready);
  modport sink (input valid, op, point_range, point_azimuth, point_is_rbs, position,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/rcet_out_if.sv =====
// result channel of the cluster extent tracker: cluster statistics per item
`default_nettype none
interface rcet_out_if;
  logic                         valid;
  logic                         ready;
  logic [rcet_pkg::COUNT_W-1:0] point_count;
  logic [rcet_pkg::RANGE_W-1:0] near_range;
  logic [rcet_pkg::RANGE_W-1:0] far_range;
  logic [rcet_pkg::AZ_W-1:0]    az_extent;
  logic                         has_rbs;
  logic                         has_uvd;
  logic [rcet_pkg::AZ_W-1:0]    last_azimuth;
  logic                         became_active;
  logic                         add_rejected;
  logic                         is_closed;

  modport source (output valid, point_count, near_range, far_range, az_extent, has_rbs,
                  has_uvd, last_azimuth, became_active, add_rejected, is_closed,
                  input ready);
  modport sink (input valid, point_count, near_range, far_range, az_extent, has_rbs,
                has_uvd, last_azimuth, became_active, add_rejected, is_closed,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/rcet_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none
module rcet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rcet_ctrl.sv =====
// controller state machine: sequences accept, shift, scan and result publish
`default_nettype none
module rcet_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rcet_pkg::stat_t stat,
  output rcet_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (stat.shift_needed) begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat.walk_done) begin
          cmd.shift_end  = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcet_dp.sv =====
// datapath: point store, count and flags, shift/scan walker, extent accumulators, result register
`default_nettype none
module rcet_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rcet_pkg::cmd_t               cmd,
  output rcet_pkg::stat_t                   stat,
  input  wire logic [1:0]                   in_op,
  input  wire logic [rcet_pkg::RANGE_W-1:0] in_range,
  input  wire logic [rcet_pkg::AZ_W-1:0]    in_azimuth,
  input  wire logic                         in_is_rbs,
  input  wire logic [rcet_pkg::POS_W-1:0]   in_position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rcet_pkg::COUNT_W-1:0]      out_point_count,
  output logic [rcet_pkg::RANGE_W-1:0]      out_near_range,
  output logic [rcet_pkg::RANGE_W-1:0]      out_far_range,
  output logic [rcet_pkg::AZ_W-1:0]         out_az_extent,
  output logic                              out_has_rbs,
  output logic                              out_has_uvd,
  output logic [rcet_pkg::AZ_W-1:0]         out_last_azimuth,
  output logic                              out_became_active,
  output logic                              out_add_rejected,
  output logic                              out_is_closed
);

  // cluster state
  logic [rcet_pkg::CNT_W-1:0]  count;
  logic                        closed;
  logic [rcet_pkg::AZ_W-1:0]   recent;

  // per-item registers
  logic [rcet_pkg::POS_W-1:0]  pos_q;
  logic                        shift_pend;
  logic                        became;
  logic                        rejected;

  // walker over stored entries
  logic [rcet_pkg::CNT_W-1:0]  idx;
  logic [rcet_pkg::ADDR_W-1:0] wr_addr;
  logic                        rd_v;
  logic                        idx_live;
  logic                        walk_step;

  // extent accumulators
  logic [rcet_pkg::RANGE_W-1:0] lo_r;
  logic [rcet_pkg::RANGE_W-1:0] hi_r;
  logic [rcet_pkg::AZ_W-1:0]    lo_a;
  logic [rcet_pkg::AZ_W-1:0]    hi_a;
  logic                         rbs;
  logic                         uvd;

  logic                         add_ok;
  logic                         is_add;
  logic                         mem_we;
  logic [rcet_pkg::ADDR_W-1:0]  mem_waddr;
  rcet_pkg::entry_t             mem_wdata;
  rcet_pkg::entry_t             new_entry;
  rcet_pkg::entry_t             rd_entry;
  logic [rcet_pkg::ENTRY_W-1:0] rd_bits;

  logic [rcet_pkg::AZ_W-1:0]    raw_span;
  logic [rcet_pkg::AZ_W-1:0]    span;

  assign is_add    = (in_op == rcet_pkg::OP_ADD);
  assign add_ok    = !closed && (count < rcet_pkg::CNT_W'(rcet_pkg::MAX_POINTS));
  assign idx_live  = (idx < count);
  assign walk_step = cmd.shift_step || cmd.scan_step;
  assign rd_entry  = rcet_pkg::entry_t'(rd_bits);

  assign new_entry.range   = in_range;
  assign new_entry.azimuth = in_azimuth;
  assign new_entry.kind    = in_is_rbs;

  // add writes at the tail; a shift writes each entry one slot down
  always_comb begin
    if (cmd.accept) begin
      mem_we    = is_add && add_ok;
      mem_waddr = count[rcet_pkg::ADDR_W-1:0];
      mem_wdata = new_entry;
    end else begin
      mem_we    = cmd.shift_step && rd_v;
      mem_waddr = wr_addr;
      mem_wdata = rd_entry;
    end
  end

  rcet_ram #(
    .WIDTH (rcet_pkg::ENTRY_W),
    .DEPTH (rcet_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx[rcet_pkg::ADDR_W-1:0]),
    .rdata (rd_bits)
  );

  assign stat.shift_needed = shift_pend;
  assign stat.walk_done    = !idx_live && !rd_v;
  assign stat.out_free     = !out_valid || out_ready;

  // wrap rule: take the short way round the turn
  always_comb begin
    raw_span = hi_a - lo_a;
    if (count < rcet_pkg::CNT_W'(2)) begin
      span = '0;
    end else if (raw_span > rcet_pkg::AZ_HALF) begin
      span = rcet_pkg::AZ_W'(rcet_pkg::AZ_TURN - {1'b0, raw_span});
    end else begin
      span = raw_span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      closed    <= 1'b0;
      recent    <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        unique case (in_op)
          rcet_pkg::OP_ADD: begin
            if (add_ok) begin
              count  <= count + rcet_pkg::CNT_W'(1);
              recent <= in_azimuth;
            end
          end
          rcet_pkg::OP_REMOVE: begin
          end
          rcet_pkg::OP_CLEAR: begin
            count  <= '0;
            closed <= 1'b0;
          end
          rcet_pkg::OP_CLOSE: begin
            closed <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.shift_end) begin
        count <= count - rcet_pkg::CNT_W'(1);
      end
      if (cmd.shift_start || cmd.scan_start) begin
        rd_v <= 1'b0;
      end else if (walk_step) begin
        rd_v <= idx_live;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_q      <= in_position;
      shift_pend <= (in_op == rcet_pkg::OP_REMOVE) && (32'(in_position) < 32'(count));
      became     <= is_add && add_ok && (count == '0);
      rejected   <= is_add && !add_ok;
    end
    if (cmd.shift_start) begin
      idx <= rcet_pkg::CNT_W'(7'(pos_q) + 7'd1);
    end
    if (cmd.scan_start) begin
      idx  <= '0;
      lo_r <= rcet_pkg::RANGE_MAX;
      hi_r <= '0;
      lo_a <= rcet_pkg::AZ_MAX;
      hi_a <= '0;
      rbs  <= 1'b0;
      uvd  <= 1'b0;
    end
    if (walk_step && idx_live) begin
      idx     <= idx + rcet_pkg::CNT_W'(1);
      wr_addr <= rcet_pkg::ADDR_W'(idx - rcet_pkg::CNT_W'(1));
    end
    if (cmd.scan_step && rd_v) begin
      if (rd_entry.range < lo_r) begin
        lo_r <= rd_entry.range;
      end
      if (rd_entry.range > hi_r) begin
        hi_r <= rd_entry.range;
      end
      if (rd_entry.azimuth < lo_a) begin
        lo_a <= rd_entry.azimuth;
      end
      if (rd_entry.azimuth > hi_a) begin
        hi_a <= rd_entry.azimuth;
      end
      if (rd_entry.kind) begin
        rbs <= 1'b1;
      end else begin
        uvd <= 1'b1;
      end
    end
    if (cmd.publish) begin
      out_point_count   <= rcet_pkg::COUNT_W'(count);
      out_near_range    <= lo_r;
      out_far_range     <= hi_r;
      out_az_extent     <= span;
      out_has_rbs       <= rbs;
      out_has_uvd       <= uvd;
      out_last_azimuth  <= recent;
      out_became_active <= became;
      out_add_rejected  <= rejected;
      out_is_closed     <= closed;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/radar_cluster_extent_tracker_top.sv =====
// top level of the radar cluster extent tracker
// Usage:
//   item_in carries one operation per item: add a point (range, azimuth, kind),
//   remove the point at a list position, clear the cluster, or close it.
//   result returns one item per operation with the point count, range extremes,
//   azimuth span, kind flags, last added azimuth and the add status flags.
// Sequence:
//   items are taken only in idle, one at a time: after acceptance the block may
//   first move entries down, then scans all held points, and the next item is
//   accepted only once the result has entered the output register. A remove at
//   a held position first moves every later entry down one place. Both walks go
//   through the single read port of the point store, one entry a cycle, so the
//   rate is set by that port.
// Reset:
//   rst empties the cluster, opens it and zeroes the last azimuth; the point
//   store itself is not cleared, only entries below the count are ever read.
// Stall:
//   the result sits in an output register; the next item is taken while it
//   waits, and that item's result is held back until the register is taken.
`default_nettype none
module radar_cluster_extent_tracker_top (
  input wire logic   clk,
  input wire logic   rst,
  rcet_in_if.sink    item_in,
  rcet_out_if.source result
);

  rcet_pkg::cmd_t  cmd;
  rcet_pkg::stat_t stat;

  rcet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcet_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (item_in.op),
    .in_range          (item_in.point_range),
    .in_azimuth        (item_in.point_azimuth),
    .in_is_rbs         (item_in.point_is_rbs),
    .in_position       (item_in.position),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .out_point_count   (result.point_count),
    .out_near_range    (result.near_range),
    .out_far_range     (result.far_range),
    .out_az_extent     (result.az_extent),
    .out_has_rbs       (result.has_rbs),
    .out_has_uvd       (result.has_uvd),
    .out_last_azimuth  (result.last_azimuth),
    .out_became_active (result.became_active),
    .out_add_rejected  (result.add_rejected),
    .out_is_closed     (result.is_closed)
  );

endmodule
`default_nettype wire

// ===== tb/sv/cluster_stats_checker.sv =====
// checker of the cluster extent tracker: predicts the statistics per operation and compares them
module cluster_stats_checker
  import rcet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rcet_in_if   item_in,
  rcet_out_if  result,
  output int   failures,
  output int   pending
);

  typedef struct packed {
    logic [COUNT_W-1:0] point_count;
    logic [RANGE_W-1:0] near_range;
    logic [RANGE_W-1:0] far_range;
    logic [AZ_W-1:0]    az_extent;
    logic               has_rbs;
    logic               has_uvd;
    logic [AZ_W-1:0]    last_azimuth;
    logic               became_active;
    logic               add_rejected;
    logic               is_closed;
  } cluster_stats_t;

  entry_t          held_pts [MAX_POINTS];
  int              held_n = 0;
  logic            shut = 1'b0;
  logic [AZ_W-1:0] recent_az = '0;
  cluster_stats_t  stats_due [$];
  int              mismatches = 0;

  assign failures = mismatches;

  function automatic cluster_stats_t cluster_apply_op(logic [1:0] op, logic [RANGE_W-1:0] rng,
                                                      logic [AZ_W-1:0] az, logic kind,
                                                      logic [POS_W-1:0] pos);
    cluster_stats_t s;
    int lo_r, hi_r, lo_a, hi_a, raw;
    s = '0;
    lo_r = RANGE_MAX;
    hi_r = 0;
    lo_a = AZ_TURN;
    hi_a = 0;
    case (op)
      OP_ADD: begin
        if (shut || held_n >= MAX_POINTS) begin
          s.add_rejected = 1'b1;
        end else begin
          s.became_active = (held_n == 0);
          held_pts[held_n].range   = rng;
          held_pts[held_n].azimuth = az;
          held_pts[held_n].kind    = kind;
          held_n++;
          recent_az = az;
        end
      end
      OP_REMOVE: begin
        // later points move down one place
        if (pos < held_n) begin
          for (int i = pos; i + 1 < held_n; i++) held_pts[i] = held_pts[i + 1];
          held_n--;
        end
      end
      OP_CLEAR: begin
        held_n = 0;
        shut   = 1'b0;
      end
      default: shut = 1'b1;
    endcase

    for (int i = 0; i < held_n; i++) begin
      if (held_pts[i].range < lo_r) lo_r = held_pts[i].range;
      if (held_pts[i].range > hi_r) hi_r = held_pts[i].range;
      if (held_pts[i].azimuth < lo_a) lo_a = held_pts[i].azimuth;
      if (held_pts[i].azimuth > hi_a) hi_a = held_pts[i].azimuth;
      if (held_pts[i].kind) s.has_rbs = 1'b1;
      else s.has_uvd = 1'b1;
    end
    if (held_n >= 2) begin
      raw = hi_a - lo_a;
      // the short way round when the plain extent passes half a turn
      s.az_extent = AZ_W'((raw > AZ_HALF) ? (AZ_TURN - hi_a) + lo_a : raw);
    end
    s.point_count  = COUNT_W'(held_n);
    s.near_range   = RANGE_W'(lo_r);
    s.far_range    = RANGE_W'(hi_r);
    s.last_azimuth = recent_az;
    s.is_closed    = shut;
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cluster_stats_t want;
    cluster_stats_t fresh;
    if (rst) begin
      held_n    = 0;
      shut      = 1'b0;
      recent_az = '0;
      stats_due.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (stats_due.size() == 0) begin
          $error("result item with no operation waiting for it");
          mismatches++;
        end else begin
          want = stats_due.pop_front();
          check_field("point_count", want.point_count, result.point_count);
          check_field("near_range", want.near_range, result.near_range);
          check_field("far_range", want.far_range, result.far_range);
          check_field("az_extent", want.az_extent, result.az_extent);
          check_field("has_rbs", want.has_rbs, result.has_rbs);
          check_field("has_uvd", want.has_uvd, result.has_uvd);
          check_field("last_azimuth", want.last_azimuth, result.last_azimuth);
          check_field("became_active", want.became_active, result.became_active);
          check_field("add_rejected", want.add_rejected, result.add_rejected);
          check_field("is_closed", want.is_closed, result.is_closed);
        end
      end
      if (item_in.valid && item_in.ready) begin
        fresh = cluster_apply_op(item_in.op, item_in.point_range, item_in.point_azimuth,
                                 item_in.point_is_rbs, item_in.position);
        stats_due.insert(stats_due.size(), fresh);
      end
    end
    pending <= stats_due.size();
  end

endmodule

// ===== tb/sv/radar_cluster_extent_tracker_top_tb.sv =====
// testbench top of the cluster extent tracker: operation stimulus, pacing of both sides, verdict
module radar_cluster_extent_tracker_top_tb;
  import rcet_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RANDOM_ITEMS   = 300;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 2 * MAX_POINTS + 16;
  localparam int TIMEOUT_CYCLES = 500000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  int              failures;
  int              pending;
  bit              quiet = 1'b0;
  bit              hold_req = 1'b0;
  int              held = 0;
  bit              shut = 1'b0;
  int              issued = 0;
  logic [AZ_W-1:0] az_base = '0;

  rcet_in_if  item_in ();
  rcet_out_if result ();

  radar_cluster_extent_tracker_top dut (
    .clk    (clk),
    .rst    (rst),
    .item_in(item_in),
    .result (result)
  );

  cluster_stats_checker stats_chk (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .result  (result),
    .failures(failures),
    .pending (pending)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // mostly azimuths clustered around a base, so spans stay near realistic sizes
  function automatic logic [AZ_W-1:0] pick_azimuth();
    if ($urandom_range(0, 2) != 0) return az_base + AZ_W'($urandom_range(0, 400));
    return AZ_W'($urandom);
  endfunction

  task automatic send_op(logic [1:0] op, logic [RANGE_W-1:0] rng, logic [AZ_W-1:0] az,
                         logic kind, logic [POS_W-1:0] pos);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_in.valid         <= 1'b1;
    item_in.op            <= op;
    item_in.point_range   <= rng;
    item_in.point_azimuth <= az;
    item_in.point_is_rbs  <= kind;
    item_in.position      <= pos;
    do @(posedge clk); while (!item_in.ready);
    issued++;
    // rough count of held points, only to aim removes at live positions
    case (op)
      OP_ADD: if (!shut && held < MAX_POINTS) held++;
      OP_REMOVE: if (pos < held) held--;
      OP_CLEAR: begin
        held = 0;
        shut = 1'b0;
      end
      default: shut = 1'b1;
    endcase
  endtask

  task automatic wait_drained();
    item_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic add_random();
    send_op(OP_ADD, RANGE_W'($urandom), pick_azimuth(), 1'($urandom_range(0, 1)),
            POS_W'($urandom));
  endtask

  // result side
  initial begin
    int stall;
    result.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) stall = LONG_HOLD;
      else stall = quiet ? 0 : $urandom_range(0, 6);
      hold_req = 1'b0;
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int choice, burst, p;
    bit paused;
    paused = 1'b0;
    item_in.valid         <= 1'b0;
    item_in.op            <= OP_ADD;
    item_in.point_range   <= '0;
    item_in.point_azimuth <= '0;
    item_in.point_is_rbs  <= 1'b0;
    item_in.position      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_op(OP_REMOVE, 16'h0000, 12'h000, 1'b0, 6'd0);     // remove from empty cluster
    send_op(OP_ADD, 16'h0000, 12'h000, 1'b0, 6'd0);        // first point wakes the cluster
    send_op(OP_ADD, 16'hFFFF, 12'hFFF, 1'b1, 6'h3F);       // span across north
    send_op(OP_ADD, 16'h8000, 12'h800, 1'b0, 6'h2A);
    send_op(OP_REMOVE, 16'hFFFF, 12'hFFF, 1'b1, 6'd63);    // position beyond count
    send_op(OP_REMOVE, 16'h0000, 12'h000, 1'b0, 6'd0);     // shifts the rest down
    send_op(OP_CLOSE, 16'h5555, 12'h555, 1'b1, 6'h15);
    send_op(OP_CLOSE, 16'hAAAA, 12'hAAA, 1'b0, 6'h2A);     // close twice
    send_op(OP_ADD, 16'h0005, 12'h005, 1'b1, 6'd0);        // refused, cluster closed
    send_op(OP_REMOVE, 16'h0000, 12'h000, 1'b0, 6'd1);     // remove last while closed
    send_op(OP_CLEAR, 16'h0000, 12'h000, 1'b0, 6'd0);      // last azimuth survives
    send_op(OP_CLOSE, 16'h0000, 12'h000, 1'b0, 6'd0);      // close an empty cluster
    send_op(OP_CLEAR, 16'hFFFF, 12'hFFF, 1'b1, 6'h3F);
    send_op(OP_ADD, 16'd100, 12'd0, 1'b1, 6'd0);
    send_op(OP_ADD, 16'd200, 12'd2048, 1'b1, 6'd0);        // span of exactly half a turn
    send_op(OP_ADD, 16'd300, 12'd2049, 1'b0, 6'd0);        // just past half: wraps
    send_op(OP_REMOVE, 16'd0, 12'd0, 1'b0, 6'd0);
    send_op(OP_REMOVE, 16'd0, 12'd0, 1'b0, 6'd1);          // one point left, no span
    send_op(OP_REMOVE, 16'd0, 12'd0, 1'b0, 6'd0);          // empty by removal
    send_op(OP_ADD, 16'd7, 12'd4095, 1'b0, 6'd0);          // wakes again
    send_op(OP_CLEAR, 16'd0, 12'd0, 1'b0, 6'd0);
    wait_drained();

    // fill the store after asking the result side for one long hold
    az_base = 12'd3900;
    send_op(OP_CLEAR, RANGE_W'($urandom), AZ_W'($urandom), 1'b0, POS_W'($urandom));
    hold_req = 1'b1;
    repeat (MAX_POINTS + 1) add_random();                  // the last one finds it full
    send_op(OP_REMOVE, RANGE_W'($urandom), AZ_W'($urandom), 1'b1, 6'd63);
    add_random();
    send_op(OP_REMOVE, RANGE_W'($urandom), AZ_W'($urandom), 1'b0, 6'd0);  // longest shift
    send_op(OP_CLOSE, RANGE_W'($urandom), AZ_W'($urandom), 1'b0, POS_W'($urandom));
    add_random();
    p = held;
    repeat (6) begin
      p = $urandom_range(0, p - 1);
      send_op(OP_REMOVE, RANGE_W'($urandom), AZ_W'($urandom), 1'($urandom_range(0, 1)),
              POS_W'(p));
    end

    // random
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      quiet = (issued >= 120 && issued < 180);
      if (!paused && issued >= 260) begin
        paused = 1'b1;
        wait_drained();
      end
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        add_random();
      end else if (choice < 72) begin
        if (held > 0 && $urandom_range(0, 3) != 0) p = $urandom_range(0, held - 1);
        else p = $urandom_range(0, 63);
        send_op(OP_REMOVE, RANGE_W'($urandom), AZ_W'($urandom), 1'($urandom_range(0, 1)),
                POS_W'(p));
      end else if (choice < 80) begin
        // batch of removes in descending order
        burst = $urandom_range(2, 5);
        p = held;
        repeat (burst) begin
          if (p > 0) begin
            p = $urandom_range(0, p - 1);
            send_op(OP_REMOVE, RANGE_W'($urandom), AZ_W'($urandom),
                    1'($urandom_range(0, 1)), POS_W'(p));
          end
        end
      end else if (choice < 86) begin
        az_base = AZ_W'($urandom);
        send_op(OP_CLEAR, RANGE_W'($urandom), AZ_W'($urandom), 1'($urandom_range(0, 1)),
                POS_W'($urandom));
      end else if (choice < 90) begin
        send_op(OP_CLOSE, RANGE_W'($urandom), AZ_W'($urandom), 1'($urandom_range(0, 1)),
                POS_W'($urandom));
      end else begin
        burst = $urandom_range(3, 12);
        repeat (burst) add_random();
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
